### src/assert_macros.svh
// assertion macros used by the rtl of the byte translator
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

### src/cbt_pkg.sv
// shared types and constants of the charset byte translator
// no dependencies
`default_nettype none

package cbt_pkg;

  localparam int unsigned TableEntries = 128;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned EntryW       = 2 * ByteW;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned InDataW      = 32;
  localparam int unsigned OutUserW     = 2;

  // transaction kinds on the input stream
  localparam logic OpTranslate = 1'b0;
  localparam logic OpLoad      = 1'b1;

  // mode register codes
  localparam logic [ModeW-1:0] ModePassLow = 2'd2;
  localparam logic [ModeW-1:0] ModeReset   = ModePassLow;

  localparam logic [ByteW-1:0] PrintLow    = 8'd32;
  localparam logic [ByteW-1:0] PrintHigh   = 8'd127;
  localparam logic [ByteW-1:0] UnknownMark = 8'h3F;

  // resolved outcome of one translate transaction
  typedef struct packed {
    logic             pair;
    logic             first_valid;
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] second_byte;
  } xlat_res_t;

endpackage

`default_nettype wire

### src/cbt_decode.sv
// classifies a table entry (or a passed-through byte) into one or two output bytes
// depends on cbt_pkg
`default_nettype none

module cbt_decode (
  input  logic                         bypass_i,
  input  logic [cbt_pkg::ByteW-1:0]    byte_i,
  input  logic [cbt_pkg::EntryW-1:0]   entry_i,
  output cbt_pkg::xlat_res_t           res_o
);

  logic [cbt_pkg::ByteW-1:0] first_b;
  logic [cbt_pkg::ByteW-1:0] second_b;
  logic                      single;
  logic                      printable;

  assign first_b   = entry_i[cbt_pkg::EntryW-1:cbt_pkg::ByteW];
  assign second_b  = entry_i[cbt_pkg::ByteW-1:0];
  assign single    = (first_b[cbt_pkg::ByteW-1:1] == '0);
  assign printable = (first_b >= cbt_pkg::PrintLow) && (first_b <= cbt_pkg::PrintHigh) &&
                     (second_b >= cbt_pkg::PrintLow);

  always_comb begin
    res_o             = '0;
    res_o.first_valid = 1'b1;
    if (bypass_i) begin
      res_o.first_byte = byte_i;
    end else if (single) begin
      // zero replacement means the byte is dropped
      res_o.first_byte  = second_b;
      res_o.first_valid = (second_b != '0);
    end else if (printable) begin
      res_o.pair        = 1'b1;
      res_o.first_byte  = first_b;
      res_o.second_byte = second_b;
    end else begin
      res_o.first_byte = cbt_pkg::UnknownMark;
    end
  end

endmodule

`default_nettype wire

### src/charset_byte_translator.sv
// top level of the charset byte translator: table memory, lookup stage, output register
// depends on cbt_pkg, cbt_decode and assert_macros.svh
//
// usage
//   input stream s_axis: tuser selects the transaction kind (0 translate a byte,
//   1 load one table entry), tlast marks the final byte of a text.
//   a load writes entry_index with {entry_first, entry_second} and yields nothing.
//   a translate yields one or two output transactions on m_axis; tlast marks the
//   last one belonging to that input byte, tuser[1] marks the end of the text.
//   a dropped byte yields one transaction with tuser[0] low and tdata zero.
//   cfg_we_i/cfg_wdata_i write the mode: 2 passes bytes below 128 unchanged,
//   any other value remaps every byte. write it only while the block is idle.
// pipeline
//   an accepted input byte passes the table read and lookup stage, then the output
//   register. a pair holds the lookup stage as the output register moves one result
//   per cycle while m_axis_tready is high; a single result frees it as it moves.
//   the table is one 128 x 16 memory with a registered read; a load and a later
//   translate never touch it in the same cycle, so no forwarding is needed.
// reset and stalls
//   reset clears the pipeline and sets the mode to 2; table contents stay
//   undefined until loaded, and reading an unloaded entry is not allowed.
//   when m_axis_tready is low the output register holds, the lookup stage fills
//   and s_axis_tready stays low while it is full; nothing is lost.
`default_nettype none
`include "assert_macros.svh"

module charset_byte_translator #(
  parameter int unsigned TABLE_ENTRIES = cbt_pkg::TableEntries
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // configuration: mode_level
  input  logic                            cfg_we_i,
  input  logic [cbt_pkg::ModeW-1:0]       cfg_wdata_i,

  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] byte_in, [14:8] entry_index, [22:15] entry_first,
  // [30:23] entry_second, [31] zero
  input  logic [cbt_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                            s_axis_tuser,   // [0] operation
  input  logic                            s_axis_tlast,   // final_byte

  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cbt_pkg::ByteW-1:0]       m_axis_tdata,   // [7:0] byte_out
  output logic [cbt_pkg::OutUserW-1:0]    m_axis_tuser,   // [0] byte_valid, [1] text_end
  output logic                            m_axis_tlast    // run_last
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned BW   = cbt_pkg::ByteW;

  // input field split
  logic [BW-1:0]   in_byte;
  logic [IdxW-1:0] in_widx;
  logic [BW-1:0]   in_first;
  logic [BW-1:0]   in_second;
  logic            in_acc;
  logic            load_acc;
  logic            xlat_acc;

  assign in_byte   = s_axis_tdata[7:0];
  assign in_widx   = s_axis_tdata[8 +: IdxW];
  assign in_first  = s_axis_tdata[22:15];
  assign in_second = s_axis_tdata[30:23];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign load_acc = in_acc && (s_axis_tuser == cbt_pkg::OpLoad);
  assign xlat_acc = in_acc && (s_axis_tuser == cbt_pkg::OpTranslate);

  // mode register
  logic [cbt_pkg::ModeW-1:0] mode_q, mode_d;

  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  // translation table, either one write or one registered read per cycle
  logic [cbt_pkg::EntryW-1:0] tbl_mem [TABLE_ENTRIES];
  logic [cbt_pkg::EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      tbl_mem[in_widx] <= {in_first, in_second};
    end
    if (xlat_acc) begin
      rdata_q <= tbl_mem[in_byte[IdxW-1:0]];
    end
  end

  // lookup stage: holds the byte while the table read completes
  logic          s1_valid_q, s1_valid_d;
  logic          phase_q, phase_d;     // first of a pair already sent
  logic [BW-1:0] s1_byte_q;
  logic          s1_fin_q;
  logic          s1_bypass_q;

  always_ff @(posedge clk_i) begin
    if (xlat_acc) begin
      s1_byte_q   <= in_byte;
      s1_fin_q    <= s_axis_tlast;
      s1_bypass_q <= (mode_q == cbt_pkg::ModePassLow) && !in_byte[BW-1];
    end
  end

  cbt_pkg::xlat_res_t res;

  cbt_decode u_decode (
    .bypass_i (s1_bypass_q),
    .byte_i   (s1_byte_q),
    .entry_i  (rdata_q),
    .res_o    (res)
  );

  // output register
  logic                         m_valid_q, m_valid_d;
  logic [BW-1:0]                m_data_q, m_data_d;
  logic [cbt_pkg::OutUserW-1:0] m_user_q, m_user_d;
  logic                         m_last_q, m_last_d;

  logic out_free;
  logic s1_emit;
  logic s1_done;

  assign out_free = !m_valid_q || m_axis_tready;
  assign s1_emit  = s1_valid_q && out_free;
  // the stage empties once its last result moves to the output register
  assign s1_done  = s1_emit && (phase_q || !res.pair);

  assign s_axis_tready = !s1_valid_q || s1_done;

  always_comb begin
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    m_last_d   = m_last_q;
    phase_d    = phase_q;
    s1_valid_d = s1_valid_q;

    if (out_free) begin
      m_valid_d = 1'b0;
    end

    if (s1_emit) begin
      m_valid_d = 1'b1;
      if (phase_q) begin
        // second byte of a pair
        m_data_d = res.second_byte;
        m_user_d = {s1_fin_q, 1'b1};
        m_last_d = 1'b1;
        phase_d  = 1'b0;
      end else begin
        m_data_d = res.first_byte;
        m_user_d = {s1_fin_q && !res.pair, res.first_valid};
        m_last_d = !res.pair;
        phase_d  = res.pair;
      end
    end

    if (s1_done) begin
      s1_valid_d = 1'b0;
    end
    if (xlat_acc) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= cbt_pkg::ModeReset;
      s1_valid_q <= 1'b0;
      phase_q    <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      s1_valid_q <= s1_valid_d;
      phase_q    <= phase_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // a pending second byte needs a live lookup stage
  `ASSERT_NEVER(a_phase_needs_s1, clk_i, rst_ni, phase_q && !s1_valid_q,
                "pair phase set with empty lookup stage")

  // the first byte of a pair in the output register implies the second is queued
  `ASSERT_AT(a_pair_first_pending, clk_i, rst_ni, (m_valid_q && !m_last_q) |-> phase_q,
             "first byte of pair shown without pending second byte")

  // no new byte while a pair is half sent and the output is blocked
  `ASSERT_AT(a_pair_blocks_input, clk_i, rst_ni, (phase_q && !out_free) |-> !s_axis_tready,
             "input accepted while pair is stalled")

  // text end only on the last result of a byte
  `ASSERT_AT(a_end_on_last, clk_i, rst_ni, (m_valid_q && m_user_q[1]) |-> m_last_q,
             "text end on a non-final result")

  // a dropped byte always comes out as zero
  `ASSERT_AT(a_drop_zero, clk_i, rst_ni, (m_valid_q && !m_user_q[0]) |-> (m_data_q == '0),
             "dropped byte with nonzero data")

endmodule

`default_nettype wire
